@@ src/tafs_pkg.sv @@
// Shared widths, codes, control structs and the cell update rule of the traffic step unit.
package tafs_pkg;

    // Default grid side; the top level hands its parameter down from this.
    localparam int MAX_SIDE_DEF = 512;

    // Field widths of the request and response beats.
    localparam int OP_W    = 2;
    localparam int COORD_W = 9;
    localparam int VAL_W   = 2;
    localparam int SIDE_W  = 10;
    localparam int COUNT_W = 19;

    localparam logic [SIDE_W-1:0]  SIDE_RESET = 10'd512;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    typedef logic [VAL_W-1:0] cell_t;

    // Cell codes. The fourth code is held as written but never survives a phase.
    localparam cell_t CELL_EMPTY = 2'd0;
    localparam cell_t CELL_RIGHT = 2'd1;
    localparam cell_t CELL_DOWN  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic take_item;
        logic cell_write;
        logic cell_read;
        logic step_begin;
        logic slot;
        logic line_next;
        logic phase_next;
        logic result_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            clear_last;
        logic [OP_W-1:0] op;
        logic            side_zero;
        logic            k_last;
        logic            line_last;
        logic            phase;
    } sts_t;

    // New content of a cell from its old neighborhood along the direction of motion.
    function automatic cell_t cell_next(cell_t prev, cell_t cur, cell_t nxt,
                                        cell_t mover, cell_t other);
        cell_t res;
        res = CELL_EMPTY;
        if (cur == mover) begin
            if (nxt != CELL_EMPTY) begin
                res = mover;
            end
        end
        else if (cur == other) begin
            res = other;
        end
        else if (cur == CELL_EMPTY && prev == mover) begin
            res = mover;
        end
        return res;
    endfunction

    // True when the car in this cell leaves it.
    function automatic logic cell_moves(cell_t cur, cell_t nxt, cell_t mover);
        return (cur == mover) && (nxt == CELL_EMPTY);
    endfunction

endpackage

@@ src/tafs_if.sv @@
// Request and response channel interfaces of the traffic step unit.
interface tafs_req_if;
    logic                              valid;
    logic                              ready;
    logic [tafs_pkg::OP_W-1:0]         operation;
    logic [tafs_pkg::COORD_W-1:0]      cell_x;
    logic [tafs_pkg::COORD_W-1:0]      cell_y;
    logic [tafs_pkg::VAL_W-1:0]        cell_value;

    modport source (output valid, output operation, output cell_x, output cell_y,
                    output cell_value, input ready);
    modport sink   (input valid, input operation, input cell_x, input cell_y,
                    input cell_value, output ready);
endinterface

interface tafs_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tafs_pkg::VAL_W-1:0]        read_value;
    logic [tafs_pkg::COUNT_W-1:0]      moved_right;
    logic [tafs_pkg::COUNT_W-1:0]      moved_down;

    modport source (output valid, output read_value, output moved_right,
                    output moved_down, input ready);
    modport sink   (input valid, input read_value, input moved_right,
                    input moved_down, output ready);
endinterface

@@ src/tafs_datapath.sv @@
// Datapath: grid memory, sweep counters, line window, move counters and result register.
module tafs_datapath #(
    parameter int MAX_SIDE = tafs_pkg::MAX_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tafs_pkg::cmd_t                cmd,
    output tafs_pkg::sts_t                sts,
    input  logic [tafs_pkg::OP_W-1:0]     operation,
    input  logic [tafs_pkg::COORD_W-1:0]  cell_x,
    input  logic [tafs_pkg::COORD_W-1:0]  cell_y,
    input  logic [tafs_pkg::VAL_W-1:0]    cell_value,
    input  logic                          cfg_we,
    input  logic [tafs_pkg::SIDE_W-1:0]   cfg_wdata,
    output logic [tafs_pkg::VAL_W-1:0]    read_value,
    output logic [tafs_pkg::COUNT_W-1:0]  moved_right,
    output logic [tafs_pkg::COUNT_W-1:0]  moved_down
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int KW    = $clog2(MAX_SIDE + 2);
    localparam int CMPW  = (SW > tafs_pkg::COORD_W) ? SW : tafs_pkg::COORD_W;
    localparam int SCW   = (SW > tafs_pkg::SIDE_W) ? SW : tafs_pkg::SIDE_W;

    // Grid memory, cell (x, y) at address {y, x}.
    tafs_pkg::cell_t grid_mem [DEPTH];

    logic [tafs_pkg::SIDE_W-1:0]  side_reg;
    logic [tafs_pkg::OP_W-1:0]    op_reg;
    logic [CW-1:0]                x_reg;
    logic [CW-1:0]                y_reg;
    tafs_pkg::cell_t              val_reg;
    logic                         in_range_reg;
    logic [AW-1:0]                clr_cnt_reg;
    logic [CW-1:0]                line_reg;
    logic [KW-1:0]                k_reg;
    logic                         phase_reg;
    logic                         tag_vld_reg;
    logic [KW-1:0]                tag_k_reg;
    tafs_pkg::cell_t              prev_reg;
    tafs_pkg::cell_t              cur_reg;
    tafs_pkg::cell_t              first_reg;
    tafs_pkg::cell_t              rdata_reg;
    logic [tafs_pkg::COUNT_W-1:0] mr_reg;
    logic [tafs_pkg::COUNT_W-1:0] md_reg;
    tafs_pkg::cell_t              read_value_reg;
    logic [tafs_pkg::COUNT_W-1:0] moved_right_reg;
    logic [tafs_pkg::COUNT_W-1:0] moved_down_reg;

    logic [SW-1:0]   side_act;
    logic [KW-1:0]   k_end;
    logic            in_range;
    logic [CW-1:0]   rd_pos;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    tafs_pkg::cell_t wr_data;
    logic            tag_first;
    logic            tag_second;
    logic            tag_last;
    logic            line_wr;
    logic [CW-1:0]   wr_pos;
    tafs_pkg::cell_t nxt;
    tafs_pkg::cell_t mover;
    tafs_pkg::cell_t other;
    tafs_pkg::cell_t new_val;
    logic            moves;

    // Side in use, limited to the grid size.
    assign side_act = (SCW'(side_reg) > SCW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_reg);
    assign k_end    = KW'(side_act) + KW'(1);
    assign in_range = (CMPW'(cell_x) < CMPW'(side_act)) && (CMPW'(cell_y) < CMPW'(side_act));

    // Status back to the controller.
    assign sts.clear_last = &clr_cnt_reg;
    assign sts.op         = op_reg;
    assign sts.side_zero  = (side_act == '0);
    assign sts.k_last     = (k_reg == k_end);
    assign sts.line_last  = (line_reg == CW'(side_act - SW'(1)));
    assign sts.phase      = phase_reg;

    // Read side: the first slot of a line fetches its far end for the wrap.
    always_comb
    begin
        rd_pos = (k_reg == '0) ? CW'(side_act - SW'(1)) : CW'(k_reg - KW'(1));
        if (cmd.slot) begin
            rd_en   = !sts.k_last;
            rd_addr = phase_reg ? {rd_pos, line_reg} : {line_reg, rd_pos};
        end
        else begin
            rd_en   = cmd.cell_read && in_range_reg;
            rd_addr = {y_reg, x_reg};
        end
    end

    // Window stage: the beat read last cycle meets the two cells before it.
    assign tag_first  = (tag_k_reg == '0);
    assign tag_second = (tag_k_reg == KW'(1));
    assign tag_last   = (tag_k_reg == k_end);
    assign line_wr    = tag_vld_reg && !tag_first && !tag_second;
    assign wr_pos     = CW'(tag_k_reg - KW'(2));
    assign nxt        = tag_last ? first_reg : rdata_reg;
    assign mover      = phase_reg ? tafs_pkg::CELL_DOWN : tafs_pkg::CELL_RIGHT;
    assign other      = phase_reg ? tafs_pkg::CELL_RIGHT : tafs_pkg::CELL_DOWN;
    assign new_val    = tafs_pkg::cell_next(prev_reg, cur_reg, nxt, mover, other);
    assign moves      = tafs_pkg::cell_moves(cur_reg, nxt, mover);

    // Write side: clearing pass, cell write or line update.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = phase_reg ? {wr_pos, line_reg} : {line_reg, wr_pos};
        wr_data = new_val;
        if (cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = tafs_pkg::CELL_EMPTY;
        end
        else if (cmd.cell_write) begin
            wr_en   = in_range_reg;
            wr_addr = {y_reg, x_reg};
            wr_data = val_reg;
        end
        else if (line_wr) begin
            wr_en = 1'b1;
        end
    end

    // Grid memory ports.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rdata_reg <= grid_mem[rd_addr];
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_reg <= tafs_pkg::SIDE_RESET;
        end
        else if (cfg_we) begin
            side_reg <= cfg_wdata;
        end
    end

    // Sweep control counters and slot tag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_cnt_reg <= '0;
            line_reg    <= '0;
            k_reg       <= '0;
            phase_reg   <= 1'b0;
            tag_vld_reg <= 1'b0;
            tag_k_reg   <= '0;
        end
        else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.step_begin) begin
                line_reg  <= '0;
                k_reg     <= '0;
                phase_reg <= 1'b0;
            end
            else if (cmd.phase_next) begin
                line_reg  <= '0;
                k_reg     <= '0;
                phase_reg <= 1'b1;
            end
            else if (cmd.line_next) begin
                line_reg <= line_reg + CW'(1);
                k_reg    <= '0;
            end
            else if (cmd.slot) begin
                k_reg <= k_reg + KW'(1);
            end
            tag_vld_reg <= cmd.slot;
            if (cmd.slot) begin
                tag_k_reg <= k_reg;
            end
        end
    end

    // Line window registers.
    always_ff @(posedge clk)
    begin
        if (tag_vld_reg) begin
            if (tag_first) begin
                prev_reg <= rdata_reg;
            end
            else if (tag_second) begin
                cur_reg   <= rdata_reg;
                first_reg <= rdata_reg;
            end
            else begin
                prev_reg <= cur_reg;
                cur_reg  <= nxt;
            end
        end
    end

    // Saturating move counters, one per phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mr_reg <= '0;
            md_reg <= '0;
        end
        else if (cmd.step_begin) begin
            mr_reg <= '0;
            md_reg <= '0;
        end
        else if (line_wr && moves) begin
            if (!phase_reg && mr_reg != tafs_pkg::COUNT_MAX) begin
                mr_reg <= mr_reg + tafs_pkg::COUNT_W'(1);
            end
            if (phase_reg && md_reg != tafs_pkg::COUNT_MAX) begin
                md_reg <= md_reg + tafs_pkg::COUNT_W'(1);
            end
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item) begin
            op_reg       <= operation;
            x_reg        <= CW'(cell_x);
            y_reg        <= CW'(cell_y);
            val_reg      <= cell_value;
            in_range_reg <= in_range;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.result_load) begin
            read_value_reg  <= (op_reg == tafs_pkg::OP_READ && in_range_reg) ?
                               rdata_reg : tafs_pkg::CELL_EMPTY;
            moved_right_reg <= (op_reg == tafs_pkg::OP_STEP) ? mr_reg : '0;
            moved_down_reg  <= (op_reg == tafs_pkg::OP_STEP) ? md_reg : '0;
        end
    end

    assign read_value  = read_value_reg;
    assign moved_right = moved_right_reg;
    assign moved_down  = moved_down_reg;

`ifndef NO_ASSERTIONS
    // A line update never lands on the cell being fetched in the same cycle.
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (line_wr && rd_en) |-> (wr_addr != rd_addr))
        else $error("line write and read hit the same cell");
`endif

endmodule

@@ src/tafs_ctrl.sv @@
// Controller: sequences the clearing pass, cell accesses, line sweeps and result hand-off.
module tafs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  tafs_pkg::sts_t sts,
    output tafs_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_DISPATCH = 6'b000100,
        ST_LINE     = 6'b001000,
        ST_DRAIN    = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    tafs_pkg::OP_WRITE:
                    begin
                        cmd.cell_write = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    tafs_pkg::OP_READ:
                    begin
                        cmd.cell_read = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    tafs_pkg::OP_STEP:
                    begin
                        cmd.step_begin = 1'b1;
                        state_next     = sts.side_zero ? ST_FINISH : ST_LINE;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_LINE:
            begin
                cmd.slot = 1'b1;
                if (sts.k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.line_last) begin
                    cmd.line_next = 1'b1;
                    state_next    = ST_LINE;
                end
                else if (!sts.phase) begin
                    cmd.phase_next = 1'b1;
                    state_next     = ST_LINE;
                end
                else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and result beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cmd.result_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // A new result only overwrites a slot that is empty or being taken.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // The last slot of a line is always followed by the drain cycle.
    a_line_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINE && sts.k_last) |=> (state_reg == ST_DRAIN))
        else $error("line sweep did not drain");

    // At most one user of the memory ports per cycle.
    a_one_user: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.cell_write, cmd.cell_read, cmd.slot}))
        else $error("memory ports claimed twice");

    // A finished item whose slot is empty shows its beat on the next cycle.
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule

@@ src/traffic_automaton_full_step_unit.sv @@
// Top level of the traffic step unit: channels, configuration and the two submodules.
// After reset the unit clears all 2**(2*clog2(MAX_SIDE)) cells of its grid memory, one
// cell per cycle (262144 cells at the default MAX_SIDE of 512), and takes no request beat
// until that pass is done; configuration writes are taken throughout.
// It then works on one request at a time. A cell write or read is captured, carried out
// in the dispatch state and loaded into the output register in the finish state. In a
// full step with side s in use, each of the two phases sweeps s lines (rows, then
// columns); each line streams its cells through the one read port of the single grid
// memory, one cell per cycle, while its one write port stores the updated cell. A finished
// response waits in an output register; while it waits the next request is accepted.
module traffic_automaton_full_step_unit #(
    parameter int MAX_SIDE = tafs_pkg::MAX_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tafs_req_if.sink                     req,
    tafs_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [tafs_pkg::SIDE_W-1:0]  cfg_wdata
);

    tafs_pkg::cmd_t cmd;
    tafs_pkg::sts_t sts;

    // Sequencer.
    tafs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Grid and arithmetic.
    tafs_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (req.operation),
        .cell_x      (req.cell_x),
        .cell_y      (req.cell_y),
        .cell_value  (req.cell_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .read_value  (rsp.read_value),
        .moved_right (rsp.moved_right),
        .moved_down  (rsp.moved_down)
    );

endmodule
